// ----- rtl/ttce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared constants, types and codes for the text terminal cursor engine.
// ----------------------------------------------------------------------------
package ttce_pkg;

   // screen geometry
   localparam int COLS = 80;
   localparam int ROWS = 25;

   // internal cursor and index widths follow the geometry
   localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W = $clog2(ROWS * COLS);

   // fixed field widths of the ports
   localparam int CHAR_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int ATTR_W      = 8;
   localparam int CELL_IDX_W  = 11;
   localparam int CELL_WORD_W = 32;
   localparam int ROW_OUT_W   = 5;
   localparam int COL_OUT_W   = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [CHAR_W-1:0] CHR_BOLD    = 8'h02;
   localparam logic [CHAR_W-1:0] CHR_BS      = 8'h08;
   localparam logic [CHAR_W-1:0] CHR_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CHR_REFRESH = 8'h0C;
   localparam logic [CHAR_W-1:0] CHR_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] CHR_DEL     = 8'hFF;
   localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FG_COLOR  = 2'd0,
      CSR_BG_COLOR  = 2'd1,
      CSR_ATTR_BITS = 2'd2,
      CSR_BOLD_MASK = 2'd3
   } csr_index_type;

   // classified operation
   typedef enum logic [2:0] {
      OP_PUT,
      OP_CR,
      OP_LF,
      OP_BS,
      OP_DEL,
      OP_BOLD,
      OP_REFRESH
   } op_type;

   // one queued transaction
   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] char_code;
   } entry_type;

   // configuration write bundle
   typedef struct packed {
      logic                  write;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_write_type;

   // one result transaction
   typedef struct packed {
      logic                   cell_write;
      logic [CELL_IDX_W-1:0]  cell_index;
      logic [CELL_WORD_W-1:0] cell_word;
      logic                   scroll_up;
      logic                   refresh;
      logic [ROW_OUT_W-1:0]   cursor_row_out;
      logic [COL_OUT_W-1:0]   cursor_col_out;
   } result_type;

endpackage

// ----- rtl/ttce_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_front
// Decodes each incoming character into an operation class for the back end.
// ----------------------------------------------------------------------------
module ttce_front (
   input  logic [ttce_pkg::CHAR_W-1:0] char_code,
   output ttce_pkg::entry_type         entry
);
   import ttce_pkg::*;

   op_type op_class;

   // control code decode, everything else is printable
   always_comb begin
      unique case (char_code)
         CHR_CR:      op_class = OP_CR;
         CHR_LF:      op_class = OP_LF;
         CHR_BS:      op_class = OP_BS;
         CHR_DEL:     op_class = OP_DEL;
         CHR_BOLD:    op_class = OP_BOLD;
         CHR_REFRESH: op_class = OP_REFRESH;
         default:     op_class = OP_PUT;
      endcase
   end

   assign entry.op        = op_class;
   assign entry.char_code = char_code;

endmodule

// ----- rtl/ttce_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_queue
// Short register queue between the decode front and the execution back end.
// ----------------------------------------------------------------------------
module ttce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ttce_pkg::entry_type push_entry,
   input  logic                pop,
   output ttce_pkg::entry_type head_entry,
   output logic                full,
   output logic                empty
);
   import ttce_pkg::*;

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign head_entry = slot_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/ttce_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_back
// Executes classified operations: cursor, bold state, configuration and the
// registered result stage.
// ----------------------------------------------------------------------------
module ttce_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ttce_pkg::csr_write_type csr,
   input  logic                    entry_valid,
   input  ttce_pkg::entry_type     entry,
   output logic                    entry_pop,
   output logic                    result_valid,
   input  logic                    result_stall,
   output ttce_pkg::result_type    result
);
   import ttce_pkg::*;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   logic [COLOR_W-1:0] fg_color_ff, fg_color_in;
   logic [COLOR_W-1:0] bg_color_ff, bg_color_in;
   logic [ATTR_W-1:0]  attr_bits_ff, attr_bits_in;
   logic [ATTR_W-1:0]  bold_mask_ff, bold_mask_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               bold_ff, bold_in;
   logic               valid_ff, valid_in;
   result_type         result_ff, result_in;

   logic [COL_W-1:0]   col_left;
   logic [COL_W-1:0]   put_col;
   logic [IDX_W-1:0]   put_idx;
   logic [ATTR_W-1:0]  attrs;
   logic [CHAR_W-1:0]  put_char;
   logic               put;
   logic               scroll;
   logic               refr;

   // pop when the result register is free or being emptied
   assign entry_pop = entry_valid && (!valid_ff || !result_stall);

   assign col_left = (col_ff != '0) ? col_ff - 1'b1 : col_ff;
   assign attrs    = attr_bits_ff ^ (bold_ff ? bold_mask_ff : '0);
   assign put_idx  = IDX_W'(row_ff) * IDX_W'(COLS) + IDX_W'(put_col);

   // operation execution
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      bold_in  = bold_ff;
      put      = 1'b0;
      put_col  = col_ff;
      put_char = entry.char_code;
      scroll   = 1'b0;
      refr     = 1'b0;

      unique case (entry.op)
         OP_CR: begin
            col_in = '0;
         end
         OP_LF: begin
            if (row_ff < LAST_ROW) begin
               row_in = row_ff + 1'b1;
            end else begin
               scroll = 1'b1;
            end
         end
         OP_BS: begin
            col_in = col_left;
         end
         OP_DEL: begin
            put      = 1'b1;
            put_col  = col_left;
            put_char = CHR_SPACE;
         end
         OP_BOLD: begin
            bold_in = !bold_ff;
         end
         OP_REFRESH: begin
            refr = 1'b1;
         end
         OP_PUT: begin
            put = 1'b1;
         end
         default: begin
            put = 1'b0;
         end
      endcase

      // advance after a cell write, wrapping with a line feed
      if (put) begin
         if (put_col < LAST_COL) begin
            col_in = put_col + 1'b1;
         end else begin
            col_in = '0;
            if (row_ff < LAST_ROW) begin
               row_in = row_ff + 1'b1;
            end else begin
               scroll = 1'b1;
            end
         end
      end

      if (!entry_pop) begin
         row_in  = row_ff;
         col_in  = col_ff;
         bold_in = bold_ff;
      end

      // writing the attribute byte clears the bold toggle
      if (csr.write && csr.index == CSR_ATTR_BITS) begin
         bold_in = 1'b0;
      end
   end

   // result word assembly
   always_comb begin
      result_in.cell_write     = put;
      result_in.cell_index     = put ? CELL_IDX_W'(put_idx) : '0;
      result_in.cell_word      = put ? {4'h0, bg_color_ff, 4'h0, fg_color_ff, attrs, put_char}
                                     : '0;
      result_in.scroll_up      = scroll;
      result_in.refresh        = refr;
      result_in.cursor_row_out = ROW_OUT_W'(row_in);
      result_in.cursor_col_out = COL_OUT_W'(col_in);
   end

   // configuration writes
   always_comb begin
      fg_color_in  = fg_color_ff;
      bg_color_in  = bg_color_ff;
      attr_bits_in = attr_bits_ff;
      bold_mask_in = bold_mask_ff;
      if (csr.write) begin
         unique case (csr_index_type'(csr.index))
            CSR_FG_COLOR:  fg_color_in  = csr.wdata[COLOR_W-1:0];
            CSR_BG_COLOR:  bg_color_in  = csr.wdata[COLOR_W-1:0];
            CSR_ATTR_BITS: attr_bits_in = csr.wdata[ATTR_W-1:0];
            CSR_BOLD_MASK: bold_mask_in = csr.wdata[ATTR_W-1:0];
            default:       fg_color_in  = fg_color_ff;
         endcase
      end
   end

   // output register handshake
   always_comb begin
      valid_in = valid_ff;
      if (entry_pop) begin
         valid_in = 1'b1;
      end else if (!result_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff  <= '0;
         bg_color_ff  <= '0;
         attr_bits_ff <= '0;
         bold_mask_ff <= ATTR_W'(1);
         row_ff       <= '0;
         col_ff       <= '0;
         bold_ff      <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         fg_color_ff  <= fg_color_in;
         bg_color_ff  <= bg_color_in;
         attr_bits_ff <= attr_bits_in;
         bold_mask_ff <= bold_mask_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         bold_ff      <= bold_in;
         valid_ff     <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (entry_pop) begin
         result_ff <= result_in;
      end
   end

   assign result_valid = valid_ff;
   assign result       = result_ff;

endmodule

// ----- rtl/text_terminal_cursor_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine_core
// Character stream to cell writes and cursor updates for a text terminal.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  req_     | in        | req_valid/req_stall  | char_code
//  rsp_     | out       | rsp_valid/rsp_stall  | cell write, scroll, refresh,
//           |           |                      | cursor row and column
//  csr_     | in        | csr_write            | csr_index, csr_wdata
//
//  One character per cycle sustained while rsp_stall stays low; the character
//  is decoded into the queue when it is taken and then executed from the queue
//  head into the result register, after which rsp_valid rises.
//  Cursor update is computed combinationally in the back end.
//  Reset is synchronous; cursor goes home, bold clears, registers take
//  their reset values. A stalled result holds the back end; the four-entry
//  queue absorbs requests until full, then req_stall rises.
// ----------------------------------------------------------------------------
module text_terminal_cursor_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ttce_pkg::CHAR_W-1:0]         req_char_code,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_cell_write,
   output logic [ttce_pkg::CELL_IDX_W-1:0]     rsp_cell_index,
   output logic [ttce_pkg::CELL_WORD_W-1:0]    rsp_cell_word,
   output logic                                rsp_scroll_up,
   output logic                                rsp_refresh,
   output logic [ttce_pkg::ROW_OUT_W-1:0]      rsp_cursor_row_out,
   output logic [ttce_pkg::COL_OUT_W-1:0]      rsp_cursor_col_out,
   input  logic                                csr_write,
   input  logic [ttce_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ttce_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ttce_pkg::*;

   entry_type     dec_entry;
   entry_type     head_entry;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   csr_write_type csr_bus;
   result_type    result;

   // decode front
   ttce_front u_front (
      .char_code (req_char_code),
      .entry     (dec_entry)
   );

   // transaction queue
   ttce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (dec_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   assign req_stall = q_full;

   assign csr_bus.write = csr_write;
   assign csr_bus.index = csr_index;
   assign csr_bus.wdata = csr_wdata;

   // execution back end
   ttce_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr_bus),
      .entry_valid  (!q_empty),
      .entry        (head_entry),
      .entry_pop    (q_pop),
      .result_valid (rsp_valid),
      .result_stall (rsp_stall),
      .result       (result)
   );

   assign rsp_cell_write     = result.cell_write;
   assign rsp_cell_index     = result.cell_index;
   assign rsp_cell_word      = result.cell_word;
   assign rsp_scroll_up      = result.scroll_up;
   assign rsp_refresh        = result.refresh;
   assign rsp_cursor_row_out = result.cursor_row_out;
   assign rsp_cursor_col_out = result.cursor_col_out;

   // no cell write leaves index and word clear
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_cell_write) |-> (rsp_cell_index == '0 && rsp_cell_word == '0))
      else $error("cell fields set without a cell write");

   // a scroll request leaves the cursor on the last row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scroll_up) |-> (rsp_cursor_row_out == ROW_OUT_W'(ROWS - 1)))
      else $error("scroll away from the last row");

   // refresh never writes a cell
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_refresh) |-> (!rsp_cell_write && !rsp_scroll_up))
      else $error("refresh combined with a write or scroll");

   // queue drains into the result stage whenever it is free
   assert property (@(posedge clock) disable iff (reset)
      (!q_empty && !rsp_valid) |=> rsp_valid)
      else $error("queued transaction not executed");

endmodule

// ----- test/cursor_engine_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_engine_checker
// Watches the character and result channels of the terminal cursor engine,
// keeps its own copy of cursor, bold toggle and color registers, predicts the
// update for every accepted character and compares each returned update with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cursor_engine_checker
   import ttce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [CHAR_W-1:0]      req_char_code,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_cell_write,
   input  logic [CELL_IDX_W-1:0]  rsp_cell_index,
   input  logic [CELL_WORD_W-1:0] rsp_cell_word,
   input  logic                   rsp_scroll_up,
   input  logic                   rsp_refresh,
   input  logic [ROW_OUT_W-1:0]   rsp_cursor_row_out,
   input  logic [COL_OUT_W-1:0]   rsp_cursor_col_out,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   // mirrored registers
   logic [COLOR_W-1:0]   fg_reg;
   logic [COLOR_W-1:0]   bg_reg;
   logic [ATTR_W-1:0]    attr_reg;
   logic [ATTR_W-1:0]    mask_reg;

   // mirrored cursor state
   logic [ROW_OUT_W-1:0] cur_row;
   logic [COL_OUT_W-1:0] cur_col;
   logic                 bold_on;

   // predicted updates still owed by the block
   result_type           due_updates[$];
   int                   result_num;

   initial begin
      fail_count = 0;
      pending    = 0;
      result_num = 0;
   end

   // one row down, or a scroll request when already on the bottom row
   function automatic logic line_feed();
      if (cur_row < ROWS - 1) begin
         cur_row = cur_row + 1'b1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // apply one character to the mirrored state and build the update it causes
   function automatic result_type advance_terminal(input logic [CHAR_W-1:0] ch);
      result_type         upd;
      logic               put;
      logic [CHAR_W-1:0]  put_char;
      logic [ATTR_W-1:0]  attrs;
      upd      = '0;
      put      = 1'b0;
      put_char = '0;
      case (ch)
         CHR_CR: begin
            cur_col = '0;
         end
         CHR_LF: begin
            upd.scroll_up = line_feed();
         end
         CHR_BS: begin
            if (cur_col != 0) cur_col = cur_col - 1'b1;
         end
         CHR_DEL: begin
            if (cur_col != 0) cur_col = cur_col - 1'b1;
            put      = 1'b1;
            put_char = CHR_SPACE;
         end
         CHR_BOLD: begin
            bold_on = ~bold_on;
         end
         CHR_REFRESH: begin
            upd.refresh = 1'b1;
         end
         default: begin
            put      = 1'b1;
            put_char = ch;
         end
      endcase
      // cell write, then advance with wrap at the right edge
      if (put) begin
         attrs          = attr_reg ^ (bold_on ? mask_reg : '0);
         upd.cell_write = 1'b1;
         upd.cell_index = CELL_IDX_W'(cur_row * COLS + cur_col);
         upd.cell_word  = {4'h0, bg_reg, 4'h0, fg_reg, attrs, put_char};
         if (cur_col < COLS - 1) begin
            cur_col = cur_col + 1'b1;
         end else begin
            cur_col       = '0;
            upd.scroll_up = line_feed();
         end
      end
      upd.cursor_row_out = cur_row;
      upd.cursor_col_out = cur_col;
      return upd;
   endfunction

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         fg_reg   = '0;
         bg_reg   = '0;
         attr_reg = '0;
         mask_reg = 8'h01;
         cur_row  = '0;
         cur_col  = '0;
         bold_on  = 1'b0;
         due_updates.delete();
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_FG_COLOR:  fg_reg = csr_wdata[COLOR_W-1:0];
               CSR_BG_COLOR:  bg_reg = csr_wdata[COLOR_W-1:0];
               CSR_ATTR_BITS: begin
                  attr_reg = csr_wdata;
                  bold_on  = 1'b0;
               end
               CSR_BOLD_MASK: mask_reg = csr_wdata;
               default: ;
            endcase
         end
         // returned update against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.cell_write     = rsp_cell_write;
            got.cell_index     = rsp_cell_index;
            got.cell_word      = rsp_cell_word;
            got.scroll_up      = rsp_scroll_up;
            got.refresh        = rsp_refresh;
            got.cursor_row_out = rsp_cursor_row_out;
            got.cursor_col_out = rsp_cursor_col_out;
            if (due_updates.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] result %0d arrived with nothing predicted", $realtime,
                           result_num);
            end else begin
               want = due_updates.pop_front();
               if (got.cell_write !== want.cell_write ||
                   got.cell_index !== want.cell_index ||
                   got.cell_word !== want.cell_word ||
                   got.scroll_up !== want.scroll_up ||
                   got.refresh !== want.refresh ||
                   got.cursor_row_out !== want.cursor_row_out ||
                   got.cursor_col_out !== want.cursor_col_out) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("[%0t] result %0d mismatch", $realtime, result_num);
                     $display("  expected wr=%0b idx=%0d word=%h scroll=%0b refr=%0b row=%0d col=%0d",
                              want.cell_write, want.cell_index, want.cell_word,
                              want.scroll_up, want.refresh, want.cursor_row_out,
                              want.cursor_col_out);
                     $display("  actual   wr=%0b idx=%0d word=%h scroll=%0b refr=%0b row=%0d col=%0d",
                              got.cell_write, got.cell_index, got.cell_word,
                              got.scroll_up, got.refresh, got.cursor_row_out,
                              got.cursor_col_out);
                  end
               end
            end
            result_num++;
         end
         // accepted character
         if (req_valid && !req_stall)
            due_updates.push_back(advance_terminal(req_char_code));
      end
      pending = due_updates.size();
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the terminal cursor engine with a directed character sequence and
// then several phases of random text under different color and attribute
// settings, with random gaps and result stalls, one stretch without random
// ones and one long result hold-off. The checker beside the block predicts
// and compares; this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import ttce_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 96;
   localparam int LONG_HOLD_AT = 220;
   localparam int LONG_HOLD    = 60;
   localparam int DRAIN_CYCLES = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CHAR_W-1:0]      req_char_code = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_cell_write;
   logic [CELL_IDX_W-1:0]  rsp_cell_index;
   logic [CELL_WORD_W-1:0] rsp_cell_word;
   logic                   rsp_scroll_up;
   logic                   rsp_refresh;
   logic [ROW_OUT_W-1:0]   rsp_cursor_row_out;
   logic [COL_OUT_W-1:0]   rsp_cursor_col_out;
   logic                   csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int                     fail_count;
   int                     pending;
   int                     cycle_count = 0;
   logic                   steady_flow = 1'b0;

   always #5 clock = ~clock;

   text_terminal_cursor_engine_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cell_write     (rsp_cell_write),
      .rsp_cell_index     (rsp_cell_index),
      .rsp_cell_word      (rsp_cell_word),
      .rsp_scroll_up      (rsp_scroll_up),
      .rsp_refresh        (rsp_refresh),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   cursor_engine_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cell_write     (rsp_cell_write),
      .rsp_cell_index     (rsp_cell_index),
      .rsp_cell_word      (rsp_cell_word),
      .rsp_scroll_up      (rsp_scroll_up),
      .rsp_refresh        (rsp_refresh),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL text_terminal_cursor_engine_core");
         $finish;
      end
   end

   // idle cycles before the next transaction on either side
   function automatic int pick_wait();
      return steady_flow ? 0 : $urandom_range(0, 9);
   endfunction

   // random character, weighted toward text with frequent line breaks
   function automatic logic [CHAR_W-1:0] pick_char();
      int                sel;
      logic [CHAR_W-1:0] ch;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         do ch = CHAR_W'($urandom_range(0, 255));
         while (ch == CHR_CR || ch == CHR_LF || ch == CHR_BS || ch == CHR_DEL ||
                ch == CHR_BOLD || ch == CHR_REFRESH);
      end else if (sel < 60) ch = CHR_LF;
      else if (sel < 68) ch = CHR_CR;
      else if (sel < 74) ch = CHR_BS;
      else if (sel < 80) ch = CHR_DEL;
      else if (sel < 85) ch = CHR_BOLD;
      else if (sel < 89) ch = CHR_REFRESH;
      else ch = CHAR_W'($urandom_range(0, 255));
      return ch;
   endfunction

   // offer one character and hold it until taken; called and returns at negedge
   task automatic send_char(input logic [CHAR_W-1:0] ch);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and let every predicted update drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // result side: random stall after each transaction, one long hold-off
   initial begin : result_side
      int taken;
      int hold;
      taken = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            taken++;
            hold = (taken == LONG_HOLD_AT) ? LONG_HOLD : pick_wait();
            if (hold > 0) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      logic [CHAR_W-1:0] directed[$];
      int                sent;
      int                run_len;
      directed = '{CHR_BS, CHR_DEL, 8'h41, 8'h00, 8'h7F, 8'h80, 8'hFE, CHR_BOLD,
                   8'h5A, CHR_DEL, CHR_BS, CHR_REFRESH, CHR_CR, CHR_LF, 8'h0B,
                   8'h0E, 8'h01, 8'h09, 8'h1B, CHR_SPACE, CHR_BOLD, CHR_BOLD};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed characters under reset register values, bold left on
      foreach (directed[i]) send_char(directed[i]);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         // extremes first, then random settings
         case (phase)
            0: begin
               write_reg(CSR_FG_COLOR, 8'h0F);
               write_reg(CSR_BG_COLOR, 8'h0F);
               write_reg(CSR_ATTR_BITS, 8'hFF);
               write_reg(CSR_BOLD_MASK, 8'hFF);
            end
            1: begin
               write_reg(CSR_FG_COLOR, 8'h00);
               write_reg(CSR_BG_COLOR, 8'h00);
               write_reg(CSR_ATTR_BITS, 8'h00);
               write_reg(CSR_BOLD_MASK, 8'h00);
            end
            default: begin
               write_reg(CSR_FG_COLOR, CSR_DATA_W'($urandom_range(0, 15)));
               write_reg(CSR_BG_COLOR, CSR_DATA_W'($urandom_range(0, 15)));
               write_reg(CSR_BOLD_MASK, CSR_DATA_W'($urandom_range(0, 255)));
               write_reg(CSR_ATTR_BITS, CSR_DATA_W'($urandom_range(0, 255)));
            end
         endcase
         steady_flow = (phase == 2);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // occasional long line of text to force wraps at the right edge
            if ($urandom_range(0, 19) == 0) begin
               run_len = $urandom_range(70, 170);
               if (run_len > PHASE_ITEMS - sent) run_len = PHASE_ITEMS - sent;
               repeat (run_len) begin
                  send_char(CHAR_W'($urandom_range(8'h20, 8'h7E)));
                  sent++;
               end
            end else begin
               send_char(pick_char());
               sent++;
            end
         end
         steady_flow = 1'b0;
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("PASS text_terminal_cursor_engine_core");
      end else begin
         $display("FAIL text_terminal_cursor_engine_core");
      end
      $finish;
   end

endmodule
